// ===== hdl/tgarle_pkg.sv =====
// ----------------------------------------------------------------------------
// TGA RLE decoder package
// Shared widths, header codes, the result job record and pixel formatting.
// ----------------------------------------------------------------------------
package tgarle_pkg;

   localparam int unsigned HeaderLen = 18;
   localparam int unsigned HdrCountW = 5;

   localparam logic [7:0] TypeRaw   = 8'd2;
   localparam logic [7:0] TypeRle   = 8'd10;
   localparam logic [7:0] RunBias   = 8'd127;
   localparam logic [7:0] FullAlpha = 8'd255;
   localparam logic [7:0] Depth8    = 8'd8;
   localparam logic [7:0] Depth24   = 8'd24;
   localparam logic [7:0] Depth32   = 8'd32;

   localparam int unsigned RspDataW = 128;
   localparam int unsigned RspUserW = 4;

   localparam logic [1:0] StPixels   = 2'd0;
   localparam logic [1:0] StHeaderOk = 2'd1;
   localparam logic [1:0] StBadSize  = 2'd2;
   localparam logic [1:0] StBadType  = 2'd3;

   // One header verdict or one decoded pixel with its repeat count.
   typedef struct packed {
      logic [1:0]  status;
      logic [15:0] width;
      logic [15:0] height;
      logic [31:0] pixel;
      logic [31:0] index;
      logic [7:0]  left;
      logic        ends_image;
   } job_type;

   // Turns the gathered file bytes (blue first) into an RGBA word.
   function automatic logic [31:0] tgarle_format(input logic [31:0] full,
                                                 input logic [2:0]  bpp);
      logic [7:0] alpha;
      alpha = (bpp == 3'd4) ? full[31:24] : FullAlpha;
      if (bpp == 3'd1) begin
         return {full[7:0], full[7:0], full[7:0], full[7:0]};
      end
      return {alpha, full[7:0], full[15:8], full[23:16]};
   endfunction

endpackage

// ===== hdl/tgarle_emit.sv =====
// ----------------------------------------------------------------------------
// TGA RLE result emitter
// Holds one pending job and splits it into results of up to two pixels,
// feeding a registered response stage.
// ----------------------------------------------------------------------------
module tgarle_emit
   import tgarle_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                load_valid,
   input  job_type             load_job,
   output logic                load_ready,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [RspDataW-1:0] rsp_tdata,
   output logic [RspUserW-1:0] rsp_tuser,
   output logic                rsp_tlast
);

   logic                job_valid_ff, job_valid_in;
   job_type             job_ff, job_in;
   logic                out_valid_ff, out_valid_in;
   logic [RspDataW-1:0] out_data_ff, out_data_in;
   logic [RspUserW-1:0] out_user_ff, out_user_in;
   logic                out_last_ff, out_last_in;
   logic                move;
   logic                pair;
   logic                final_step;
   logic                load_take;

   assign move       = job_valid_ff && (!out_valid_ff || rsp_tready);
   assign pair       = (job_ff.left >= 8'd2);
   assign final_step = (job_ff.left <= 8'd2);
   assign load_ready = !job_valid_ff || (move && final_step);
   assign load_take  = load_valid && load_ready;

   always_comb begin
      job_valid_in = job_valid_ff;
      job_in       = job_ff;
      out_valid_in = out_valid_ff;
      out_data_in  = out_data_ff;
      out_user_in  = out_user_ff;
      out_last_in  = out_last_ff;
      if (move) begin
         job_in.index = job_ff.index + (pair ? 32'd2 : 32'd1);
         job_in.left  = job_ff.left - (pair ? 8'd2 : 8'd1);
         if (final_step) begin
            job_valid_in = 1'b0;
         end
         out_valid_in = 1'b1;
         out_data_in  = {job_ff.index, (pair ? job_ff.pixel : 32'd0), job_ff.pixel,
                         job_ff.height, job_ff.width};
         out_user_in  = {final_step && job_ff.ends_image, pair, job_ff.status};
         out_last_in  = final_step;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
      if (load_take) begin
         job_valid_in = 1'b1;
         job_in       = load_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         job_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         job_valid_ff <= job_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      job_ff      <= job_in;
      out_data_ff <= out_data_in;
      out_user_ff <= out_user_in;
      out_last_ff <= out_last_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tuser  = out_user_ff;
   assign rsp_tlast  = out_last_ff;

endmodule

// ===== hdl/tga_rle_pixel_decoder_unit.sv =====
// ----------------------------------------------------------------------------
// TGA RLE pixel decoder
// Parses a TGA byte stream (types 2 and 10, depth 8/24/32) into RGBA pixels.
// ----------------------------------------------------------------------------
//  Channel  Dir  Width            Contents
//  req      in   tdata 8, user 1  file byte; tuser marks byte 0 of a new file
//  rsp      out  tdata 128, user 4, tlast  header verdict or one/two pixels
//
// One request is taken per cycle unless req_tready is low; a byte that completes
// a raw pixel or a header gives one response via the job and response registers.
// A run of c pixels gives ceil(c/2) responses, one per cycle from the job register
// while rsp_tready is high, and req_tready stays low until the last of them moves out.
// Reset is synchronous and returns the parser to the header phase.
// A stalled response port holds the job register, which in turn holds req.
// ----------------------------------------------------------------------------
module tga_rle_pixel_decoder_unit
   import tgarle_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [7:0]          req_tdata,  // [7:0] data_byte
   input  logic [0:0]          req_tuser,  // [0] file_start
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [RspDataW-1:0] rsp_tdata,  // image_width, image_height,
                                           // pixel_first, pixel_second, pixel_index
   output logic [RspUserW-1:0] rsp_tuser,  // status[1:0], second_valid, image_done
   output logic                rsp_tlast   // run_last
);

   typedef enum logic [2:0] {
      PH_HEADER,
      PH_IDSKIP,
      PH_CHUNK,
      PH_PIXEL,
      PH_IDLE
   } phase_type;

   phase_type            phase_ff, phase_in, phase_cur;
   logic [HdrCountW-1:0] hcnt_ff, hcnt_in, hcnt_cur;
   logic [7:0]           id_skip_ff, id_skip_in;
   logic [15:0]          width_ff, width_in;
   logic [15:0]          height_ff, height_in;
   logic [2:0]           bpp_ff, bpp_in;
   logic                 compressed_ff, compressed_in;
   logic                 type_ok_ff, type_ok_in;
   logic [23:0]          color_ff, color_in;
   logic [1:0]           bip_ff, bip_in;
   logic [7:0]           chunk_left_ff, chunk_left_in;
   logic                 run_ff, run_in;
   logic [31:0]          done_ff, done_in;
   logic [31:0]          total_ff, total_in;

   logic        req_accept;
   logic        load_valid;
   logic        load_ready;
   job_type     load_job;
   logic [7:0]  b;
   logic [31:0] full;
   logic [31:0] remaining;
   logic [7:0]  count;
   logic [7:0]  count_eff;
   logic [31:0] done_new;
   phase_type   data_phase;

   assign req_tready = load_ready;
   assign req_accept = req_tvalid && req_tready;
   assign b          = req_tdata;
   assign data_phase = compressed_ff ? PH_CHUNK : PH_PIXEL;
   assign full       = {8'd0, color_ff} | ({24'd0, b} << {bip_ff, 3'b000});
   assign remaining  = total_ff - done_ff;
   assign count      = (compressed_ff && run_ff) ? chunk_left_ff : 8'd1;
   assign count_eff  = (remaining < {24'd0, count}) ? remaining[7:0] : count;
   assign done_new   = done_ff + {24'd0, count_eff};

   always_comb begin
      phase_cur     = req_tuser[0] ? PH_HEADER : phase_ff;
      hcnt_cur      = req_tuser[0] ? '0 : hcnt_ff;
      phase_in      = phase_ff;
      hcnt_in       = hcnt_ff;
      id_skip_in    = id_skip_ff;
      width_in      = width_ff;
      height_in     = height_ff;
      bpp_in        = bpp_ff;
      compressed_in = compressed_ff;
      type_ok_in    = type_ok_ff;
      color_in      = color_ff;
      bip_in        = bip_ff;
      chunk_left_in = chunk_left_ff;
      run_in        = run_ff;
      done_in       = done_ff;
      total_in      = total_ff;
      load_valid    = 1'b0;
      load_job      = '0;
      load_job.left = 8'd1;
      if (req_accept) begin
         phase_in = phase_cur;
         hcnt_in  = hcnt_cur;
         case (phase_cur)
            PH_HEADER: begin
               case (hcnt_cur)
                  5'd0:  id_skip_in = b;
                  5'd2: begin
                     compressed_in = (b == TypeRle);
                     type_ok_in    = (b == TypeRaw) || (b == TypeRle);
                  end
                  5'd12: width_in[7:0]   = b;
                  5'd13: width_in[15:8]  = b;
                  5'd14: height_in[7:0]  = b;
                  5'd15: height_in[15:8] = b;
                  5'd16: begin
                     if (b == Depth8) begin
                        bpp_in = 3'd1;
                     end else if (b == Depth24) begin
                        bpp_in = 3'd3;
                     end else if (b == Depth32) begin
                        bpp_in = 3'd4;
                     end else begin
                        bpp_in = 3'd0;
                     end
                  end
                  default: ;
               endcase
               hcnt_in = hcnt_cur + 5'd1;
               if (hcnt_cur == HdrCountW'(HeaderLen - 1)) begin
                  load_valid = 1'b1;
                  if (width_ff == '0 || height_ff == '0 || bpp_ff == '0) begin
                     load_job.status = StBadSize;
                     phase_in        = PH_IDLE;
                  end else if (!type_ok_ff) begin
                     load_job.status = StBadType;
                     phase_in        = PH_IDLE;
                  end else begin
                     load_job.status = StHeaderOk;
                     load_job.width  = width_ff;
                     load_job.height = height_ff;
                     total_in        = {16'd0, width_ff} * {16'd0, height_ff};
                     done_in         = '0;
                     color_in        = '0;
                     bip_in          = '0;
                     chunk_left_in   = '0;
                     run_in          = 1'b0;
                     phase_in        = (id_skip_ff != '0) ? PH_IDSKIP : data_phase;
                  end
               end
            end
            PH_IDSKIP: begin
               id_skip_in = id_skip_ff - 8'd1;
               if (id_skip_ff == 8'd1) begin
                  phase_in = data_phase;
               end
            end
            PH_CHUNK: begin
               run_in        = b[7];
               chunk_left_in = b[7] ? (b - RunBias) : (b + 8'd1);
               bip_in        = '0;
               color_in      = '0;
               phase_in      = PH_PIXEL;
            end
            PH_PIXEL: begin
               if (({1'b0, bip_ff} + 3'd1) < bpp_ff && bip_ff != 2'd3) begin
                  color_in = color_ff | full[23:0];
                  bip_in   = bip_ff + 2'd1;
               end else begin
                  bip_in              = '0;
                  color_in            = '0;
                  load_valid          = 1'b1;
                  load_job.status     = StPixels;
                  load_job.pixel      = tgarle_format(full, bpp_ff);
                  load_job.index      = done_ff;
                  load_job.left       = count_eff;
                  load_job.ends_image = (done_new == total_ff);
                  done_in             = done_new;
                  if (done_new == total_ff) begin
                     phase_in = PH_IDLE;
                  end else if (compressed_ff) begin
                     if (run_ff) begin
                        phase_in = PH_CHUNK;
                     end else begin
                        chunk_left_in = chunk_left_ff - 8'd1;
                        if (chunk_left_ff == 8'd1) begin
                           phase_in = PH_CHUNK;
                        end
                     end
                  end
               end
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_HEADER;
         hcnt_ff       <= '0;
         id_skip_ff    <= '0;
         width_ff      <= '0;
         height_ff     <= '0;
         bpp_ff        <= '0;
         compressed_ff <= 1'b0;
         type_ok_ff    <= 1'b0;
         color_ff      <= '0;
         bip_ff        <= '0;
         chunk_left_ff <= '0;
         run_ff        <= 1'b0;
         done_ff       <= '0;
         total_ff      <= '0;
      end else begin
         phase_ff      <= phase_in;
         hcnt_ff       <= hcnt_in;
         id_skip_ff    <= id_skip_in;
         width_ff      <= width_in;
         height_ff     <= height_in;
         bpp_ff        <= bpp_in;
         compressed_ff <= compressed_in;
         type_ok_ff    <= type_ok_in;
         color_ff      <= color_in;
         bip_ff        <= bip_in;
         chunk_left_ff <= chunk_left_in;
         run_ff        <= run_in;
         done_ff       <= done_in;
         total_ff      <= total_in;
      end
   end

   tgarle_emit u_emit (
      .clock      (clock),
      .reset      (reset),
      .load_valid (load_valid),
      .load_job   (load_job),
      .load_ready (load_ready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   // While pixel data is expected, the image cannot already be complete.
   assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_PIXEL || phase_ff == PH_CHUNK || phase_ff == PH_IDSKIP)
      |-> (done_ff < total_ff))
      else $error("pixel count reached the image size outside the idle phase");

   // The final pixel of an image always closes the results of its byte.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser[3]) |-> rsp_tlast)
      else $error("image end flagged on a response that is not the last of its byte");

   // A header verdict is a single response with no pixel payload.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser[1:0] != StPixels)
      |-> (rsp_tlast && !rsp_tuser[2] && rsp_tdata[127:32] == '0))
      else $error("header verdict carries pixel data");

endmodule
